[design/fcms_pkg.sv]
package fcms_pkg;

    localparam int SKETCH_ROWS = 4;
    localparam int COLUMN_BITS = 16;
    localparam int COUNT_WIDTH = 32;
    localparam int SKETCH_DEPTH = 1 << COLUMN_BITS;

    // hash slice given to each row, fixed by the 64-bit hash split
    localparam int LANE_BITS = 16;
    localparam int COL_PORT_BITS = 16;
    localparam int CNT_PORT_BITS = 32;

    localparam int TUPLE_LEN = 13;
    localparam int OUT_BITS = 2 + SKETCH_ROWS * (COL_PORT_BITS + CNT_PORT_BITS);
    localparam int OUT_WIDTH = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [63:0] FH_M = 64'h880355f21e6d1965;
    localparam logic [63:0] FH_MIX = 64'h2127599bf4325c37;
    localparam logic [63:0] HASH_SEED = 64'd77;
    localparam logic [63:0] HASH_INIT = HASH_SEED ^ (64'd13 * FH_M);

    localparam logic [5:0] POS_MAX = 6'd63;
    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    localparam logic [1:0] STATUS_COUNTED = 2'd0;
    localparam logic [1:0] STATUS_SHORT = 2'd1;
    localparam logic [1:0] STATUS_NOT_IPV4 = 2'd2;
    localparam logic [1:0] STATUS_NOT_L4 = 2'd3;

endpackage

[design/fcms_ram.sv]
module fcms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/flow_count_min_sketch_top.sv]
// steps: a dropped frame has its result word loaded in the classify state; a counted frame
// goes through classify, five 64-bit multiplies (operand load, four passes over one 32x32
// multiplier, hash update), then counter read and write-back
// throughput: one frame byte per cycle; after each last word the input waits until the
// result word is loaded, which takes longer while the output stalls
// reset: asynchronous active low; after release the counter memories are cleared,
// one address per cycle in all four rows, with input held off
module flow_count_min_sketch_top
    import fcms_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // s_tdata: frame_byte [7:0]
    input  logic [7:0]           s_tdata,
    // s_tlast: last_byte
    input  logic                 s_tlast,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // m_tdata: status [1:0], row0_column..row3_column [65:2] (16 each),
    // row0_count..row3_count [193:66] (32 each), zero fill [199:194]
    output logic [OUT_WIDTH-1:0] m_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_CLS   = 3'd2;
    localparam logic [2:0] ST_LOAD  = 3'd3;
    localparam logic [2:0] ST_MUL   = 3'd4;
    localparam logic [2:0] ST_OPEND = 3'd5;
    localparam logic [2:0] ST_READ  = 3'd6;
    localparam logic [2:0] ST_WRITE = 3'd7;

    // hash program steps
    localparam logic [2:0] OP_MIX0 = 3'd0;
    localparam logic [2:0] OP_MUL0 = 3'd1;
    localparam logic [2:0] OP_MIX1 = 3'd2;
    localparam logic [2:0] OP_MUL1 = 3'd3;
    localparam logic [2:0] OP_FIN  = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [COLUMN_BITS-1:0] clr_addr_reg, clr_addr_next;
    logic [5:0]             pos_reg, pos_next;
    logic [15:0]            ether_reg, ether_next;
    logic [7:0]             proto_reg, proto_next;
    logic [7:0]             tuple_reg [TUPLE_LEN];
    logic [7:0]             tuple_next [TUPLE_LEN];
    logic [1:0]             status_reg, status_next;
    logic [2:0]             op_reg, op_next;
    logic [1:0]             phase_reg, phase_next;
    logic [63:0]            x_reg, x_next;
    logic [63:0]            k_reg, k_next;
    logic [63:0]            prod_reg, prod_next;
    logic [63:0]            acc_reg, acc_next;
    logic [63:0]            h_reg, h_next;
    logic                   m_valid_reg, m_valid_next;
    logic [OUT_WIDTH-1:0]   m_data_reg, m_data_next;

    logic                   accept;
    logic                   out_free;
    logic                   out_load;
    logic [6:0]             frame_len;
    logic [63:0]            lane0, lane1;
    logic [63:0]            acc_mix;
    logic [31:0]            mul_a, mul_b;
    logic [63:0]            mul_p;
    logic                   ram_we, ram_re;
    logic [COLUMN_BITS-1:0] col [SKETCH_ROWS];
    logic [COLUMN_BITS-1:0] ram_waddr [SKETCH_ROWS];
    logic [COUNT_WIDTH-1:0] ram_wdata [SKETCH_ROWS];
    logic [COUNT_WIDTH-1:0] ram_rdata [SKETCH_ROWS];
    logic [COUNT_WIDTH-1:0] cnt_inc [SKETCH_ROWS];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // fasthash reads the tuple as two little-endian words
    always_comb
    begin
        lane0 = 64'd0;
        lane1 = 64'd0;
        for (int i = 0; i < 8; i++)
        begin
            lane0[8*i +: 8] = tuple_reg[i];
        end
        for (int i = 8; i < TUPLE_LEN; i++)
        begin
            lane1[8*(i-8) +: 8] = tuple_reg[i];
        end
    end

    assign acc_mix = acc_reg ^ (acc_reg >> 47);

    // one 32x32 multiplier; a 64-bit product mod 2^64 takes three partial products
    assign mul_a = (phase_reg == 2'd2) ? x_reg[63:32] : x_reg[31:0];
    assign mul_b = (phase_reg == 2'd1) ? k_reg[63:32] : k_reg[31:0];
    assign mul_p = mul_a * mul_b;

    assign frame_len = {1'b0, pos_reg} + 7'd1;

    generate
        for (genvar r = 0; r < SKETCH_ROWS; r++)
        begin : g_row
            assign col[r]       = h_reg[LANE_BITS*r +: COLUMN_BITS];
            assign cnt_inc[r]   = ram_rdata[r] + COUNT_WIDTH'(1);
            assign ram_waddr[r] = (state_reg == ST_CLEAR) ? clr_addr_reg : col[r];
            assign ram_wdata[r] = (state_reg == ST_CLEAR) ? '0 : cnt_inc[r];

            fcms_ram #(
                .WIDTH (COUNT_WIDTH),
                .DEPTH (SKETCH_DEPTH)
            ) u_row_ram (
                .clk   (clk),
                .we    (ram_we),
                .waddr (ram_waddr[r]),
                .wdata (ram_wdata[r]),
                .re    (ram_re),
                .raddr (col[r]),
                .rdata (ram_rdata[r])
            );
        end
    endgenerate

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        pos_next      = pos_reg;
        ether_next    = ether_reg;
        proto_next    = proto_reg;
        tuple_next    = tuple_reg;
        status_next   = status_reg;
        op_next       = op_reg;
        phase_next    = phase_reg;
        x_next        = x_reg;
        k_next        = k_reg;
        prod_next     = prod_reg;
        acc_next      = acc_reg;
        h_next        = h_reg;
        m_data_next   = m_data_reg;
        out_load      = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we        = 1'b1;
                clr_addr_next = clr_addr_reg + COLUMN_BITS'(1);
                if (&clr_addr_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    // header capture at fixed byte offsets
                    if (pos_reg == 6'd12 || pos_reg == 6'd13)
                    begin
                        ether_next = {ether_reg[7:0], s_tdata};
                    end
                    if (pos_reg == 6'd23)
                    begin
                        proto_next = s_tdata;
                        tuple_next[TUPLE_LEN-1] = s_tdata;
                    end
                    if (pos_reg >= 6'd26 && pos_reg <= 6'd37)
                    begin
                        tuple_next[4'(pos_reg - 6'd26)] = s_tdata;
                    end
                    if (pos_reg < POS_MAX)
                    begin
                        pos_next = pos_reg + 6'd1;
                    end
                    if (s_tlast)
                    begin
                        // frame-length checks as the header fields decide them
                        if (frame_len <= 7'd14)
                        begin
                            status_next = STATUS_SHORT;
                        end
                        else if (ether_next != ETH_IPV4)
                        begin
                            status_next = STATUS_NOT_IPV4;
                        end
                        else if (frame_len <= 7'd34)
                        begin
                            status_next = STATUS_SHORT;
                        end
                        else if (proto_next == PROTO_TCP)
                        begin
                            status_next = (frame_len >= 7'd54) ? STATUS_COUNTED : STATUS_SHORT;
                        end
                        else if (proto_next == PROTO_UDP)
                        begin
                            status_next = (frame_len >= 7'd42) ? STATUS_COUNTED : STATUS_SHORT;
                        end
                        else
                        begin
                            status_next = STATUS_NOT_L4;
                        end
                        pos_next   = 6'd0;
                        ether_next = 16'd0;
                        proto_next = 8'd0;
                        state_next = ST_CLS;
                    end
                end
            end
            ST_CLS:
            begin
                if (status_reg != STATUS_COUNTED)
                begin
                    if (out_free)
                    begin
                        m_data_next = '0;
                        m_data_next[1:0] = status_reg;
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    op_next    = OP_MIX0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                case (op_reg)
                    OP_MIX0:
                    begin
                        x_next = lane0 ^ (lane0 >> 23);
                        k_next = FH_MIX;
                    end
                    OP_MIX1:
                    begin
                        x_next = lane1 ^ (lane1 >> 23);
                        k_next = FH_MIX;
                    end
                    OP_FIN:
                    begin
                        x_next = h_reg ^ (h_reg >> 23);
                        k_next = FH_MIX;
                    end
                    default:
                    begin
                        x_next = h_reg;
                        k_next = FH_M;
                    end
                endcase
                phase_next = 2'd0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = mul_p;
                phase_next = phase_reg + 2'd1;
                case (phase_reg)
                    2'd0:
                    begin
                        acc_next = acc_reg;
                    end
                    2'd1:
                    begin
                        acc_next = prod_reg;
                    end
                    default:
                    begin
                        acc_next[63:32] = acc_reg[63:32] + prod_reg[31:0];
                    end
                endcase
                if (phase_reg == 2'd3)
                begin
                    state_next = ST_OPEND;
                end
            end
            ST_OPEND:
            begin
                op_next    = op_reg + 3'd1;
                state_next = ST_LOAD;
                case (op_reg)
                    OP_MIX0:
                    begin
                        h_next = HASH_INIT ^ acc_mix;
                    end
                    OP_MIX1:
                    begin
                        h_next = h_reg ^ acc_mix;
                    end
                    OP_FIN:
                    begin
                        h_next     = acc_mix;
                        state_next = ST_READ;
                    end
                    default:
                    begin
                        h_next = acc_reg;
                    end
                endcase
            end
            ST_READ:
            begin
                ram_re     = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                // read data holds until the next read, so waiting on the output is safe
                if (out_free)
                begin
                    ram_we = 1'b1;
                    m_data_next = '0;
                    m_data_next[1:0] = STATUS_COUNTED;
                    for (int r = 0; r < SKETCH_ROWS; r++)
                    begin
                        m_data_next[2 + COL_PORT_BITS*r +: COL_PORT_BITS] =
                            COL_PORT_BITS'(col[r]);
                        m_data_next[2 + COL_PORT_BITS*SKETCH_ROWS + CNT_PORT_BITS*r
                                    +: CNT_PORT_BITS] = CNT_PORT_BITS'(cnt_inc[r]);
                    end
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            pos_reg      <= 6'd0;
            ether_reg    <= 16'd0;
            proto_reg    <= 8'd0;
            for (int i = 0; i < TUPLE_LEN; i++)
            begin
                tuple_reg[i] <= 8'd0;
            end
            status_reg   <= STATUS_COUNTED;
            op_reg       <= OP_MIX0;
            phase_reg    <= 2'd0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            pos_reg      <= pos_next;
            ether_reg    <= ether_next;
            proto_reg    <= proto_next;
            tuple_reg    <= tuple_next;
            status_reg   <= status_next;
            op_reg       <= op_next;
            phase_reg    <= phase_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        k_reg      <= k_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        h_reg      <= h_next;
        m_data_reg <= m_data_next;
    end

endmodule
